### rtl/sc1a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 decoder package
// Shared types, key codes and the two-column key table.
// ----------------------------------------------------------------------------
package sc1a_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] ROM_ROWS    = 7'h3B;
  localparam logic [6:0] PLAIN_LIMIT = 7'h0E;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
  localparam logic [6:0] KEY_SHIFT_R = 7'h36;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_CAPS    = 7'h3A;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } key_flags_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       unknown_key;
  } key_result_t;

  // Returns {unshifted, shifted} character for a table row; zero means none.
  function automatic logic [13:0] key_row(input logic [5:0] row);
    logic [13:0] r;
    case (row)
      6'h00: r = {7'h30, 7'h30};
      6'h01: r = {7'h1B, 7'h1B};
      6'h02: r = {7'h31, 7'h21};
      6'h03: r = {7'h32, 7'h40};
      6'h04: r = {7'h33, 7'h23};
      6'h05: r = {7'h34, 7'h24};
      6'h06: r = {7'h35, 7'h25};
      6'h07: r = {7'h36, 7'h5E};
      6'h08: r = {7'h37, 7'h26};
      6'h09: r = {7'h38, 7'h2A};
      6'h0A: r = {7'h39, 7'h28};
      6'h0B: r = {7'h30, 7'h29};
      6'h0C: r = {7'h2D, 7'h5F};
      6'h0D: r = {7'h3D, 7'h2B};
      6'h0E: r = {7'h08, 7'h08};
      6'h0F: r = {7'h09, 7'h09};
      6'h10: r = {7'h71, 7'h51};
      6'h11: r = {7'h77, 7'h57};
      6'h12: r = {7'h65, 7'h45};
      6'h13: r = {7'h72, 7'h52};
      6'h14: r = {7'h74, 7'h54};
      6'h15: r = {7'h79, 7'h59};
      6'h16: r = {7'h75, 7'h55};
      6'h17: r = {7'h69, 7'h49};
      6'h18: r = {7'h6F, 7'h4F};
      6'h19: r = {7'h70, 7'h50};
      6'h1A: r = {7'h5B, 7'h7B};
      6'h1B: r = {7'h5D, 7'h7D};
      6'h1C: r = {7'h0D, 7'h0D};
      6'h1E: r = {7'h61, 7'h41};
      6'h1F: r = {7'h73, 7'h53};
      6'h20: r = {7'h64, 7'h44};
      6'h21: r = {7'h66, 7'h46};
      6'h22: r = {7'h67, 7'h47};
      6'h23: r = {7'h68, 7'h48};
      6'h24: r = {7'h6A, 7'h4A};
      6'h25: r = {7'h6B, 7'h4B};
      6'h26: r = {7'h6C, 7'h4C};
      6'h27: r = {7'h3B, 7'h3A};
      6'h28: r = {7'h27, 7'h22};
      6'h29: r = {7'h60, 7'h7E};
      6'h2B: r = {7'h5C, 7'h7C};
      6'h2C: r = {7'h7A, 7'h5A};
      6'h2D: r = {7'h78, 7'h58};
      6'h2E: r = {7'h63, 7'h43};
      6'h2F: r = {7'h76, 7'h56};
      6'h30: r = {7'h62, 7'h42};
      6'h31: r = {7'h6E, 7'h4E};
      6'h32: r = {7'h6D, 7'h4D};
      6'h33: r = {7'h2C, 7'h3C};
      6'h34: r = {7'h2E, 7'h3E};
      6'h35: r = {7'h2F, 7'h3F};
      6'h37: r = {7'h2A, 7'h2A};
      6'h39: r = {7'h20, 7'h20};
      default: r = 14'h0000;
    endcase
    return r;
  endfunction

endpackage

### rtl/sc1a_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 byte decoder
// Decodes one scan byte against the prefix mark and the modifier flags,
// giving the result and the next prefix mark and flags.
// ----------------------------------------------------------------------------
module sc1a_decode (
  input  logic [7:0]           scan_byte,
  input  logic                 prefix,
  input  sc1a_pkg::key_flags_t flags,
  output logic                 prefix_next,
  output sc1a_pkg::key_flags_t flags_next,
  output sc1a_pkg::key_result_t result
);
  import sc1a_pkg::*;

  logic [6:0]  low7;
  logic [5:0]  row;
  logic [13:0] entry;
  logic        in_rom;
  logic        shift_only;
  logic        col;
  logic [6:0]  ch;

  assign low7  = scan_byte[6:0];
  assign row   = low7[5:0];
  assign entry = key_row(row);

  always_comb begin
    prefix_next = 1'b0;
    flags_next  = flags;
    result      = '0;
    in_rom      = 1'b0;
    shift_only  = 1'b0;
    col         = 1'b0;
    ch          = 7'd0;
    if (scan_byte == PREFIX_BYTE) begin
      prefix_next = 1'b1;
    end else if (scan_byte[7]) begin
      if (low7 == KEY_CTRL) begin
        flags_next.ctrl = 1'b0;
      end else if (!prefix && (low7 == KEY_SHIFT_L || low7 == KEY_SHIFT_R)) begin
        flags_next.shift = 1'b0;
      end else if (low7 == KEY_ALT) begin
        flags_next.alt = 1'b0;
      end
    end else begin
      if (prefix) begin
        in_rom = (low7 == KEY_CTRL) || (low7 == KEY_ALT);
      end else begin
        in_rom = (low7 != 7'd0) && (low7 < ROM_ROWS);
        shift_only = (low7 < PLAIN_LIMIT) ||
                     (low7 inside {7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29,
                                   7'h2B, 7'h33, 7'h34, 7'h35});
      end
      if (in_rom) begin
        col = shift_only ? flags.shift : (flags.shift ^ flags.caps);
        ch  = col ? entry[6:0] : entry[13:7];
        if (ch != 7'd0) begin
          result.char_valid = 1'b1;
          result.char_code  = ch;
        end else if (low7 == KEY_CTRL) begin
          flags_next.ctrl = 1'b1;
        end else if (low7 == KEY_SHIFT_L || low7 == KEY_SHIFT_R) begin
          flags_next.shift = 1'b1;
        end else if (low7 == KEY_ALT) begin
          flags_next.alt = 1'b1;
        end else if (low7 == KEY_CAPS) begin
          flags_next.caps = ~flags.caps;
        end
      end else begin
        result.unknown_key = 1'b1;
      end
    end
    if (scan_byte == PREFIX_BYTE && prefix) begin
      prefix_next = 1'b1;
    end
  end

endmodule

### rtl/scancode_set1_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan code set 1 to ASCII converter
// Turns keyboard scan code set 1 bytes into characters and modifier state.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result, in order. The block takes one
// byte per cycle: a byte lands in the input register, is decoded in one pass
// through the key table and the modifier logic, and is written to the result
// register. The E0 prefix byte itself gives a result with no character and the
// current modifier flags. Both sides may stall freely; the input stalls only
// when both registers are full.
module scancode_set1_to_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] scan_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       char_valid,
  output logic [6:0] char_code,
  output logic       unknown_key,
  output logic       shift_held,
  output logic       ctrl_held,
  output logic       alt_held,
  output logic       caps_on
);
  import sc1a_pkg::*;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        prefix;
  logic        prefix_next;
  key_flags_t  flags;
  key_flags_t  flags_next;
  key_result_t dec_result;
  logic        accept;
  logic        advance;

  assign advance    = in_full && !(result_valid && result_stall);
  assign byte_stall = in_full && result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  sc1a_decode u_decode (
    .scan_byte   (in_byte),
    .prefix      (prefix),
    .flags       (flags),
    .prefix_next (prefix_next),
    .flags_next  (flags_next),
    .result      (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
      prefix       <= 1'b0;
      flags        <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        prefix       <= prefix_next;
        flags        <= flags_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= scan_byte;
    end
    if (advance) begin
      char_valid  <= dec_result.char_valid;
      char_code   <= dec_result.char_code;
      unknown_key <= dec_result.unknown_key;
    end
  end

  assign shift_held = flags.shift;
  assign ctrl_held  = flags.ctrl;
  assign alt_held   = flags.alt;
  assign caps_on    = flags.caps;

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && char_valid |-> char_code != 7'd0)
    else $error("character transfer with a zero code");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !char_valid |-> char_code == 7'd0)
    else $error("code not zero without a character");

  a_char_or_unknown: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(char_valid && unknown_key))
    else $error("character and unknown key in one transfer");

  a_prefix_mark: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == PREFIX_BYTE |=> prefix)
    else $error("prefix byte did not set the prefix mark");

endmodule
